// ===== rtl/bcdec_pkg.sv =====
// ----------------------------------------------------------------------------
// bcdec_pkg: shared types and constants
// Types for the decoded-palette queue and block format codes of the BC1/BC3
// block decompressor.
// ----------------------------------------------------------------------------
package bcdec_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = QueuePtrW + 1;

  localparam logic [3:0] LastPixel    = 4'd15;
  localparam logic [1:0] PalBlackIdx  = 2'd3;
  localparam logic [7:0] AlphaOpaque  = 8'd255;
  localparam logic [7:0] AlphaClear   = 8'd0;

  typedef enum logic {
    FMT_BC1 = 1'b0,
    FMT_BC3 = 1'b1
  } fmt_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // One decoded block: colour palette, alpha palette and the raw indices
  typedef struct packed {
    rgb_t [3:0]      pal;
    logic            four;
    logic [7:0][7:0] apal;
    logic [31:0]     cidx;
    logic [47:0]     aidx;
  } entry_t;

endpackage

// ===== rtl/bcdec_ifs.sv =====
// ----------------------------------------------------------------------------
// bcdec channel interfaces
// Valid/ready channels for compressed blocks, decoded pixels and the
// format register write.
// ----------------------------------------------------------------------------
interface bcdec_blk_if;
  logic        valid;
  logic        ready;
  logic [15:0] endpoint_zero;
  logic [15:0] endpoint_one;
  logic [31:0] colour_indices;
  logic [7:0]  alpha_zero;
  logic [7:0]  alpha_one;
  logic [47:0] alpha_indices;

  modport source (output valid, endpoint_zero, endpoint_one, colour_indices,
                  alpha_zero, alpha_one, alpha_indices, input ready);
  modport sink   (input valid, endpoint_zero, endpoint_one, colour_indices,
                  alpha_zero, alpha_one, alpha_indices, output ready);
endinterface

interface bcdec_pix_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_number;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_pixel;

  modport source (output valid, pixel_number, red, green, blue, alpha,
                  last_pixel, input ready);
  modport sink   (input valid, pixel_number, red, green, blue, alpha,
                  last_pixel, output ready);
endinterface

interface bcdec_cfg_if;
  logic valid;
  logic ready;
  logic block_format;

  modport source (output valid, block_format, input ready);
  modport sink   (input valid, block_format, output ready);
endinterface

// ===== rtl/bc1_bc3_block_decompressor.sv =====
// ----------------------------------------------------------------------------
// bc1_bc3_block_decompressor: BC1/BC3 texture block decoder
// Decodes one compressed 4x4 block per input beat into sixteen RGBA pixel
// beats in raster order.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  blk      in   one compressed block (endpoints, indices, alpha block)
//  pix      out  one decoded pixel, last_pixel on the sixteenth
//  cfg      in   block_format write (0 = BC1, 1 = BC3)
//
//  The pixel sequencer emits one pixel per cycle while a block is queued
//  and pix is not stalled. The first pixel passes the second palette stage,
//  the queue write and the output register after the block is taken.
//  Synchronous reset clears the pipeline valids, queue and pixel counter,
//  and sets the format to BC1.
//  A stalled pix channel holds its beat; blk keeps being taken until the
//  front stages and the two-entry queue are full.
// ----------------------------------------------------------------------------
module bc1_bc3_block_decompressor (
  input  logic        clk,
  input  logic        rst,
  bcdec_blk_if.sink   blk,
  bcdec_pix_if.source pix,
  bcdec_cfg_if.sink   cfg
);

  bcdec_pkg::fmt_t    fmt;
  logic               q_valid;
  bcdec_pkg::entry_t  q_data;
  logic               q_ready;
  logic               head_valid;
  bcdec_pkg::entry_t  head;
  logic               pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= bcdec_pkg::FMT_BC1;
    end else if (cfg.valid) begin
      fmt <= bcdec_pkg::fmt_t'(cfg.block_format);
    end
  end

  bcdec_front u_front (
    .clk     (clk),
    .rst     (rst),
    .blk     (blk),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_ready (q_ready)
  );

  bcdec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_valid),
    .push_data  (q_data),
    .push_ready (q_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  bcdec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fmt        (fmt),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .pix        (pix)
  );

endmodule

// ===== rtl/bcdec_front.sv =====
// ----------------------------------------------------------------------------
// bcdec_front: block decode front end
// Two-stage pipeline: widen endpoints and form weighted sums, then divide
// by reciprocal multiply and build the colour and alpha palettes.
// ----------------------------------------------------------------------------
module bcdec_front (
  input  logic                clk,
  input  logic                rst,
  bcdec_blk_if.sink           blk,
  output logic                q_valid,
  output bcdec_pkg::entry_t   q_data,
  input  logic                q_ready
);

  function automatic bcdec_pkg::rgb_t expand565(input logic [15:0] c);
    bcdec_pkg::rgb_t o;
    o.r = {c[15:11], c[15:13]};
    o.g = {c[10:5], c[10:9]};
    o.b = {c[4:0], c[4:2]};
    return o;
  endfunction

  // x / 3 for x < 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // x / 7 for x < 1792
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd2341;
    return p[21:14];
  endfunction

  // x / 5 for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd3277;
    return p[21:14];
  endfunction

  // stage A registers
  logic                 a_valid;
  logic [2:0][7:0]      a_c0;
  logic [2:0][7:0]      a_c1;
  logic [2:0][9:0]      a_s2;
  logic [2:0][9:0]      a_s3;
  logic [2:0][7:0]      a_half;
  logic                 a_four;
  logic [7:0]           a_a0;
  logic [7:0]           a_a1;
  logic                 a_amode8;
  logic [7:2][10:0]     a_asum;
  logic [31:0]          a_cidx;
  logic [47:0]          a_aidx;

  logic [2:0][7:0]      c0_x;
  logic [2:0][7:0]      c1_x;
  logic [2:0][9:0]      s2_next;
  logic [2:0][9:0]      s3_next;
  logic [2:0][7:0]      half_next;
  logic [8:0]           pair;
  logic                 amode8_next;
  logic [7:2][10:0]     asum_next;
  logic [10:0]          s7;
  logic [10:0]          s5;

  logic                 b_free;
  logic                 a_free;
  bcdec_pkg::entry_t    e_next;
  logic [2:0][7:0]      p2;
  logic [2:0][7:0]      p3;

  assign b_free    = !q_valid || q_ready;
  assign a_free    = !a_valid || b_free;
  assign blk.ready = a_free;

  always_comb begin
    c0_x        = expand565(blk.endpoint_zero);
    c1_x        = expand565(blk.endpoint_one);
    amode8_next = blk.alpha_zero > blk.alpha_one;
    for (int ch = 0; ch < 3; ch++) begin
      s2_next[ch]   = {1'b0, c0_x[ch], 1'b0} + 10'(c1_x[ch]);
      s3_next[ch]   = 10'(c0_x[ch]) + {1'b0, c1_x[ch], 1'b0};
      pair          = 9'(c0_x[ch]) + 9'(c1_x[ch]);
      half_next[ch] = pair[8:1];
    end
    for (int k = 2; k < 8; k++) begin
      s7 = 11'(8 - k) * 11'(blk.alpha_zero) + 11'(k - 1) * 11'(blk.alpha_one);
      if (k < 6) begin
        s5 = 11'(6 - k) * 11'(blk.alpha_zero) + 11'(k - 1) * 11'(blk.alpha_one);
      end else begin
        s5 = '0;
      end
      asum_next[k] = amode8_next ? s7 : s5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= blk.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && blk.valid) begin
      a_c0     <= c0_x;
      a_c1     <= c1_x;
      a_s2     <= s2_next;
      a_s3     <= s3_next;
      a_half   <= half_next;
      a_four   <= blk.endpoint_zero > blk.endpoint_one;
      a_a0     <= blk.alpha_zero;
      a_a1     <= blk.alpha_one;
      a_amode8 <= amode8_next;
      a_asum   <= asum_next;
      a_cidx   <= blk.colour_indices;
      a_aidx   <= blk.alpha_indices;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      p2[ch] = a_four ? div3(a_s2[ch]) : a_half[ch];
      p3[ch] = a_four ? div3(a_s3[ch]) : 8'd0;
    end
    e_next.pal[0]  = bcdec_pkg::rgb_t'(a_c0);
    e_next.pal[1]  = bcdec_pkg::rgb_t'(a_c1);
    e_next.pal[2]  = bcdec_pkg::rgb_t'(p2);
    e_next.pal[3]  = bcdec_pkg::rgb_t'(p3);
    e_next.four    = a_four;
    e_next.apal[0] = a_a0;
    e_next.apal[1] = a_a1;
    for (int k = 2; k < 8; k++) begin
      if (a_amode8) begin
        e_next.apal[k] = div7(a_asum[k]);
      end else if (k == 6) begin
        e_next.apal[k] = bcdec_pkg::AlphaClear;
      end else if (k == 7) begin
        e_next.apal[k] = bcdec_pkg::AlphaOpaque;
      end else begin
        e_next.apal[k] = div5(a_asum[k]);
      end
    end
    e_next.cidx = a_cidx;
    e_next.aidx = a_aidx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (b_free) begin
      q_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_valid) begin
      q_data <= e_next;
    end
  end

endmodule

// ===== rtl/bcdec_queue.sv =====
// ----------------------------------------------------------------------------
// bcdec_queue: decoded block queue
// Short FIFO of decoded palettes between the front end and the pixel
// sequencer.
// ----------------------------------------------------------------------------
module bcdec_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bcdec_pkg::entry_t  push_data,
  output logic               push_ready,
  output logic               head_valid,
  output bcdec_pkg::entry_t  head,
  input  logic               pop
);

  bcdec_pkg::entry_t                     mem [bcdec_pkg::QueueDepth];
  logic [bcdec_pkg::QueuePtrW-1:0]       wr_ptr;
  logic [bcdec_pkg::QueuePtrW-1:0]       rd_ptr;
  logic [bcdec_pkg::QueueCntW-1:0]       count;
  logic                                  do_push;
  logic                                  do_pop;

  assign push_ready = count != bcdec_pkg::QueueCntW'(bcdec_pkg::QueueDepth);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == bcdec_pkg::QueuePtrW'(bcdec_pkg::QueueDepth - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == bcdec_pkg::QueuePtrW'(bcdec_pkg::QueueDepth - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/bcdec_back.sv =====
// ----------------------------------------------------------------------------
// bcdec_back: pixel sequencer
// Walks the sixteen pixels of the head block, looks up colour and alpha,
// and drives the registered pixel output.
// ----------------------------------------------------------------------------
module bcdec_back (
  input  logic               clk,
  input  logic               rst,
  input  bcdec_pkg::fmt_t    fmt,
  input  logic               head_valid,
  input  bcdec_pkg::entry_t  head,
  output logic               pop,
  bcdec_pix_if.source        pix
);

  logic [3:0]       pnum;
  logic             advance;
  logic             take;
  logic [1:0]       ci;
  logic [2:0]       acode;
  bcdec_pkg::rgb_t  colour;
  logic [7:0]       alpha_next;

  assign advance = !pix.valid || pix.ready;
  assign take    = advance && head_valid;
  assign pop     = take && (pnum == bcdec_pkg::LastPixel);

  always_comb begin
    ci     = head.cidx[{pnum, 1'b0} +: 2];
    acode  = head.aidx[6'(pnum) * 6'd3 +: 3];
    colour = head.pal[ci];
    if (fmt == bcdec_pkg::FMT_BC3) begin
      alpha_next = head.apal[acode];
    end else if (ci == bcdec_pkg::PalBlackIdx && !head.four) begin
      alpha_next = bcdec_pkg::AlphaClear;
    end else begin
      alpha_next = bcdec_pkg::AlphaOpaque;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
      pnum      <= '0;
    end else begin
      if (advance) begin
        pix.valid <= head_valid;
      end
      if (take) begin
        pnum <= pnum + 1'b1;
      end
    end
  end

  // hold the beat while stalled
  always_ff @(posedge clk) begin
    if (take) begin
      pix.pixel_number <= pnum;
      pix.red          <= colour.r;
      pix.green        <= colour.g;
      pix.blue         <= colour.b;
      pix.alpha        <= alpha_next;
      pix.last_pixel   <= pnum == bcdec_pkg::LastPixel;
    end
  end

endmodule
